// ===== rtl/rsst_pkg.sv =====
`default_nettype none

package rsst_pkg;

  // Default number of leaf elements in the tree.
  localparam int LeavesDef = 1024;

  // Field widths of an operation and of a result.
  localparam int IdxW = 10;
  localparam int EndW = 11;
  localparam int ValW = 32;
  localparam int SumW = 42;

  // Operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/rsst_ram.sv =====
`default_nettype none

module rsst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one read port; the read data is registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/range_sum_segment_tree.sv =====
`default_nettype none
// Sum segment tree: point writes and half-open range sum queries.
// A write keeps busy high while it stores the leaf and recomputes each sum on its path to the root; it gives no result.
// A query strobes its result when its walk ends; the walk steps through S_QA and S_QB
// at each level, since the node memory has a single read port.
// The receiver cannot stall; each result is shown for exactly one cycle.
// After reset the node memory is swept to zero, one entry a cycle, over all 2*LEAVES entries.

module range_sum_segment_tree
  import rsst_pkg::*;
#(
  parameter int LEAVES = LeavesDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   opcode_i,
  input  wire logic [IdxW-1:0]        index_i,
  input  wire logic [EndW-1:0]        range_end_i,
  input  wire logic signed [ValW-1:0] value_i,
  output logic                        result_strobe_o,
  output logic signed [SumW-1:0]      range_sum_o
);

  localparam int Nodes = 2 * LEAVES;
  localparam int AW    = $clog2(Nodes);
  localparam int NW    = AW + 1;

  typedef enum logic [6:0] {
    S_CLR   = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_WLEAF = 7'b0000100,
    S_WUP   = 7'b0001000,
    S_QA    = 7'b0010000,
    S_QB    = 7'b0100000,
    S_QOUT  = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  logic [NW-1:0]   a_q, a_d;
  logic [NW-1:0]   b_q, b_d;
  logic [SumW-1:0] acc_q, acc_d;
  logic            pend_q, pend_d;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [SumW-1:0] ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [SumW-1:0] ram_rdata;

  logic            accept;
  logic [31:0]     end_clamp;
  logic [NW-1:0]   a_init;
  logic [NW-1:0]   b_init;
  logic [NW-1:0]   k_up;
  logic [NW-1:0]   a_inc;
  logic [NW-1:0]   b_dec;
  logic [SumW-1:0] sum_w;
  logic [SumW-1:0] value_ext;

  assign accept = start && !busy;

  // Query bounds mapped to leaf node numbers; an empty range walks nothing.
  assign end_clamp = (32'(range_end_i) > 32'(LEAVES)) ? 32'(LEAVES) : 32'(range_end_i);
  assign a_init    = (32'(index_i) < end_clamp) ? NW'(32'(index_i) + 32'(LEAVES)) : '0;
  assign b_init    = (32'(index_i) < end_clamp) ? NW'(end_clamp + 32'(LEAVES)) : '0;

  assign value_ext = {{(SumW - ValW){value_i[ValW-1]}}, value_i};
  assign k_up      = a_q >> 1;
  assign a_inc     = a_q + NW'(1);
  assign b_dec     = b_q - NW'(1);

  // One adder serves both the path recompute and the query accumulation.
  assign sum_w = acc_q + ram_rdata;

  // Sequencer: clear sweep, write path walk and a query walk through S_QA then S_QB per level.
  always_comb begin
    state_d   = state_q;
    a_d       = a_q;
    b_d       = b_q;
    acc_d     = acc_q;
    pend_d    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = a_q[AW-1:0];
    ram_wdata = '0;
    ram_raddr = a_q[AW-1:0];
    case (state_q)
      S_CLR: begin
        ram_we = 1'b1;
        a_d    = a_inc;
        if (a_q == NW'(Nodes - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          acc_d = '0;
          if (opcode_i == OP_QUERY) begin
            a_d     = a_init;
            b_d     = b_init;
            state_d = S_QA;
          end else if (32'(index_i) < 32'(LEAVES)) begin
            a_d     = NW'(32'(index_i) + 32'(LEAVES));
            acc_d   = value_ext;
            state_d = S_WLEAF;
          end
        end
      end
      S_WLEAF: begin
        // Store the leaf and fetch its sibling.
        ram_we    = 1'b1;
        ram_wdata = acc_q;
        ram_raddr = {a_q[AW-1:1], ~a_q[0]};
        state_d   = S_WUP;
      end
      S_WUP: begin
        // Parent gets this node plus its sibling; fetch the parent's sibling meanwhile.
        ram_we    = 1'b1;
        ram_waddr = k_up[AW-1:0];
        ram_wdata = sum_w;
        ram_raddr = {k_up[AW-1:1], ~k_up[0]};
        acc_d     = sum_w;
        a_d       = k_up;
        if (k_up == NW'(1)) begin
          state_d = S_IDLE;
        end
      end
      S_QA: begin
        if (pend_q) begin
          acc_d = sum_w;
        end
        if (a_q < b_q) begin
          if (a_q[0]) begin
            pend_d = 1'b1;
            a_d    = a_inc;
          end
          state_d = S_QB;
        end else begin
          state_d = S_QOUT;
        end
      end
      S_QB: begin
        if (pend_q) begin
          acc_d = sum_w;
        end
        ram_raddr = b_dec[AW-1:0];
        if (b_q[0]) begin
          pend_d = 1'b1;
        end
        a_d     = a_q >> 1;
        b_d     = b_q >> 1;
        state_d = S_QA;
      end
      S_QOUT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      a_q     <= '0;
      b_q     <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      a_q     <= a_d;
      b_q     <= b_d;
      pend_q  <= pend_d;
    end
  end

  // Accumulator, also the running path sum of a write.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  rsst_ram #(
    .Width(SumW),
    .Depth(Nodes)
  ) u_nodes (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign busy            = (state_q != S_IDLE);
  assign result_strobe_o = (state_q == S_QOUT);
  assign range_sum_o     = acc_q;

`ifndef SYNTHESIS
  // A result only follows the end of a query walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(state_q == S_QA))
    else $error("result strobe without a finished query walk");

  // A query never writes the node memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QA || state_q == S_QB || state_q == S_QOUT) |-> !ram_we)
    else $error("node memory written during a query");

  // The path walk stops at the root.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WUP) |-> (a_q > NW'(1)))
    else $error("write walk went past the root");

  // No result can appear in the cycle after a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !result_strobe_o)
    else $error("result strobe right after a transfer");

  // Query reads stay inside the node memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QA && a_q < b_q) |-> (b_q <= NW'(Nodes)))
    else $error("query bound outside the tree");
`endif

endmodule

`default_nettype wire

// ===== test/range_sum_segment_tree_tb.sv =====
`timescale 1ns / 1ps

module range_sum_segment_tree_tb;
  import rsst_pkg::*;

  // Cycles with no transfer at all before the run is declared hung.
  localparam int StallLimit = 20000;
  // Longest query walk plus some slack, waited out at the end.
  localparam int DrainCycles = 32;
  localparam int RandomOps = 830;
  localparam int NumDirected = 23;

  // One operation as it is presented on the command ports.
  typedef struct {
    logic                   op;
    logic [IdxW-1:0]        idx;
    logic [EndW-1:0]        rend;
    logic signed [ValW-1:0] val;
    bit                     pinned;
    logic signed [SumW-1:0] sum;
  } tree_op_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic                   opcode_i;
  logic [IdxW-1:0]        index_i;
  logic [EndW-1:0]        range_end_i;
  logic signed [ValW-1:0] value_i;
  logic                   result_strobe_o;
  logic signed [SumW-1:0] range_sum_o;

  // A fixed expected sum travels with the command it belongs to.
  bit                     pin_valid;
  logic signed [SumW-1:0] pin_sum;

  // Shadow copy of the node sums and the sums still owed by the block.
  logic signed [SumW-1:0] shadow_tree [2*LeavesDef];
  logic signed [SumW-1:0] sums_due_q [$];
  logic signed [SumW-1:0] due_sum;

  int fail_count;
  int write_count;
  int query_count;
  int empty_count;
  int checked_count;
  int quiet_cycles;

  tree_op_t directed_ops [NumDirected];

  range_sum_segment_tree dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .index_i        (index_i),
    .range_end_i    (range_end_i),
    .value_i        (value_i),
    .result_strobe_o(result_strobe_o),
    .range_sum_o    (range_sum_o)
  );

  always #2 clk_i = ~clk_i;

  // Replace one leaf and recompute every sum on its path to the root.
  function automatic void store_leaf(input logic [IdxW-1:0] idx,
                                     input logic signed [ValW-1:0] val);
    int k;
    k = int'(idx) + LeavesDef;
    shadow_tree[k] = {{(SumW - ValW){val[ValW-1]}}, val};
    while (k > 1) begin
      k = k >> 1;
      shadow_tree[k] = shadow_tree[2*k] + shadow_tree[2*k+1];
    end
  endfunction

  // Sum over [lo, hi), with hi clamped to the leaf count; walks up from both bounds.
  function automatic logic signed [SumW-1:0] span_total(input logic [IdxW-1:0] lo,
                                                       input logic [EndW-1:0] hi);
    int a;
    int b;
    logic signed [SumW-1:0] acc;
    acc = '0;
    a = int'(lo);
    b = (int'(hi) > LeavesDef) ? LeavesDef : int'(hi);
    if (a < b) begin
      a = a + LeavesDef;
      b = b + LeavesDef;
      while (a < b) begin
        if (a % 2 == 1) begin
          acc = acc + shadow_tree[a];
          a = a + 1;
        end
        if (b % 2 == 1) begin
          b = b - 1;
          acc = acc + shadow_tree[b];
        end
        a = a >> 1;
        b = b >> 1;
      end
    end
    return acc;
  endfunction

  // Idle cycles before the next command; each one more is added with a chance of about a quarter.
  function automatic int idle_gap();
    int n;
    n = 0;
    while (n < 12 && $urandom_range(99) < 24) begin
      n++;
    end
    return n;
  endfunction

  // Random command, with weight on leaf ends, value extremes and odd bounds.
  function automatic tree_op_t random_op();
    tree_op_t row;
    int pick;
    int lo;
    row.op = ($urandom_range(99) < 45) ? OP_WRITE : OP_QUERY;
    row.idx = IdxW'($urandom());
    row.rend = EndW'($urandom());
    row.val = $urandom();
    row.pinned = 1'b0;
    row.sum = '0;
    if (row.op == OP_WRITE) begin
      if ($urandom_range(9) < 3) begin
        row.idx = IdxW'(($urandom_range(1) ? 0 : LeavesDef - 16) + $urandom_range(15));
      end
      pick = $urandom_range(9);
      case (pick)
        0: row.val = 32'h7FFF_FFFF;
        1: row.val = 32'h8000_0000;
        2: row.val = ValW'($signed($urandom_range(20)) - 10);
        default: ;
      endcase
    end else begin
      lo = $urandom_range(LeavesDef - 1);
      row.idx = IdxW'(lo);
      pick = $urandom_range(9);
      case (pick)
        0: begin
          row.idx = '0;
          row.rend = EndW'(LeavesDef);
        end
        1: row.rend = EndW'($urandom_range(lo));
        2: row.rend = EndW'($urandom_range(LeavesDef + 1, 2047));
        3, 4: row.rend = EndW'((lo + 8 > LeavesDef) ? LeavesDef : lo + $urandom_range(8));
        default: row.rend = EndW'($urandom_range(lo, LeavesDef));
      endcase
    end
    return row;
  endfunction

  // Present one command and hold it until the block takes it.
  task automatic send_op(input tree_op_t row, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    opcode_i <= row.op;
    index_i <= row.idx;
    range_end_i <= row.rend;
    value_i <= row.val;
    pin_valid <= row.pinned;
    pin_sum <= row.sum;
    do @(posedge clk_i); while (busy);
  endtask

  // Check results against the oldest owed sum, then predict for a new transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_strobe_o) begin
        if (sums_due_q.size() == 0) begin
          fail_count++;
          $display("%0t: range_sum with no query pending: expected none, got %0d",
                   $time, range_sum_o);
        end else begin
          due_sum = sums_due_q.pop_front();
          checked_count++;
          if (range_sum_o !== due_sum) begin
            fail_count++;
            $display("%0t: range_sum mismatch: expected %0d, got %0d",
                     $time, due_sum, range_sum_o);
          end
        end
      end
      if (start && !busy) begin
        if (opcode_i == OP_WRITE) begin
          write_count++;
          store_leaf(index_i, value_i);
        end else begin
          query_count++;
          if (int'(index_i) >= int'(range_end_i)) empty_count++;
          sums_due_q.push_back(pin_valid ? pin_sum : span_total(index_i, range_end_i));
        end
      end
      // Watchdog on cycles with no transfer in either direction.
      if ((start && !busy) || result_strobe_o) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("%0t: no transfer for %0d cycles, giving up", $time, StallLimit);
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  // Stimulus: directed table, then random commands, then drain.
  initial begin
    start = 1'b0;
    opcode_i = OP_WRITE;
    index_i = '0;
    range_end_i = '0;
    value_i = '0;
    pin_valid = 1'b0;
    pin_sum = '0;
    fail_count = 0;
    write_count = 0;
    query_count = 0;
    empty_count = 0;
    checked_count = 0;
    quiet_cycles = 0;
    for (int i = 0; i < 2 * LeavesDef; i++) begin
      shadow_tree[i] = '0;
    end

    // Fixed sums only where they are obvious; the rest come from the shadow tree.
    directed_ops = '{
      // Empty tree right after reset, empty range, reversed bounds, clamped end.
      '{OP_QUERY,    0, 1024, 32'sd0, 1'b1, 42'sd0},
      '{OP_QUERY,    5,    5, 32'sd0, 1'b1, 42'sd0},
      '{OP_QUERY,  700,    3, 32'sd0, 1'b1, 42'sd0},
      '{OP_QUERY,    0, 2047, 32'sd0, 1'b1, 42'sd0},
      // Writes at both ends with both value extremes and alternating bits.
      '{OP_WRITE,    0,    0, 32'h7FFF_FFFF, 1'b0, 42'sd0},
      '{OP_WRITE, 1023,    0, 32'h8000_0000, 1'b0, 42'sd0},
      '{OP_WRITE,  512, 1500, 32'hFFFF_FFFF, 1'b0, 42'sd0},
      '{OP_WRITE,    1,    0, 32'sd1, 1'b0, 42'sd0},
      '{OP_WRITE,  341, 2047, 32'h5555_5555, 1'b0, 42'sd0},
      '{OP_WRITE,  682,    0, 32'hAAAA_AAAA, 1'b0, 42'sd0},
      // Single leaves at the extremes, a clamped end, an empty last leaf and wider spans.
      '{OP_QUERY,    0,    1, 32'sd0, 1'b1, 42'sd2147483647},
      '{OP_QUERY, 1023, 1024, 32'sd0, 1'b1, -42'sd2147483648},
      '{OP_QUERY, 1023, 2047, 32'sd0, 1'b1, -42'sd2147483648},
      '{OP_QUERY, 1023, 1023, 32'sd0, 1'b1, 42'sd0},
      '{OP_QUERY,    0, 1024, 32'sd0, 1'b0, 42'sd0},
      '{OP_QUERY,    0, 2047, 32'sd0, 1'b0, 42'sd0},
      '{OP_QUERY,    1, 1023, 32'sd0, 1'b0, 42'sd0},
      '{OP_QUERY,  512,  513, 32'sd0, 1'b1, -42'sd1},
      '{OP_QUERY,  341,  683, 32'sd0, 1'b0, 42'sd0},
      // Overwrite a leaf at each end and check the new pair sums.
      '{OP_WRITE,    0,    0, 32'h8000_0000, 1'b0, 42'sd0},
      '{OP_QUERY,    0,    2, 32'sd0, 1'b1, -42'sd2147483647},
      '{OP_WRITE, 1023,    0, 32'sd0, 1'b0, 42'sd0},
      '{OP_QUERY, 1022, 1024, 32'sd0, 1'b0, 42'sd0}
    };

    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_ops[i]) begin
      send_op(directed_ops[i], idle_gap());
    end

    for (int i = 0; i < RandomOps; i++) begin
      if (i == 500) begin
        // Hold off until every owed sum has come back.
        start <= 1'b0;
        @(posedge clk_i);
        while (sums_due_q.size() != 0) @(posedge clk_i);
      end
      // A long run of back-to-back commands in the middle.
      send_op(random_op(), (i >= 300 && i < 450) ? 0 : idle_gap());
    end
    start <= 1'b0;

    while (sums_due_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sums_due_q.size() != 0) begin
      fail_count++;
      $display("%0t: %0d sums never arrived", $time, sums_due_q.size());
    end

    $display("Covered %0d point writes and %0d range queries (%0d with an empty range).",
             write_count, query_count, empty_count);
    $display("Compared %0d range sums; %0d errors.", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== range_sum_segment_tree.f =====
rtl/rsst_pkg.sv
rtl/rsst_ram.sv
rtl/range_sum_segment_tree.sv
test/range_sum_segment_tree_tb.sv
